[rtl/blp_pkg.sv]
// ----------------------------------------------------------------------------
// Bresenham line points: shared types
// Command and status bundles between controller and datapath, and the
// controller's state encoding.
// ----------------------------------------------------------------------------
package blp_pkg;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture a new line and work out its deltas
		logic setup;  // choose the major axis and seed the error term
		logic step;   // advance one point and present it on the output
	} blp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic len_zero;   // the captured line has no points to emit
		logic last_step;  // the next step produces the end point
		logic out_free;   // the output register can take a point this cycle
	} blp_status_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_RUN   = 3'b100
	} blp_state_t;

endpackage

[rtl/blp_if.sv]
// ----------------------------------------------------------------------------
// Bresenham line points: channel interfaces
// Valid/ready channels for the incoming lines and the outgoing points.
// ----------------------------------------------------------------------------
interface blp_line_if #(
	parameter int unsigned COORD_BITS = 6
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

interface blp_point_if #(
	parameter int unsigned COORD_BITS = 6
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] point_x;
	logic [COORD_BITS-1:0] point_y;
	logic                  last_point;

	modport source (output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink (input valid, input point_x, input point_y, input last_point,
		output ready);
endinterface

[rtl/blp_ctrl.sv]
// ----------------------------------------------------------------------------
// Bresenham line points: controller
// Sequences load, setup and one step per free output slot for each line.
// ----------------------------------------------------------------------------
module blp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  blp_pkg::blp_status_t status,
	output blp_pkg::blp_cmd_t    cmd
);

	blp_pkg::blp_state_t state_q;
	blp_pkg::blp_state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			blp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = blp_pkg::ST_SETUP;
				end
			end
			blp_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = status.len_zero ? blp_pkg::ST_IDLE : blp_pkg::ST_RUN;
			end
			blp_pkg::ST_RUN: begin
				if (status.out_free) begin
					cmd.step = 1'b1;
					if (status.last_step) begin
						state_d = blp_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = blp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/blp_dp.sv]
// ----------------------------------------------------------------------------
// Bresenham line points: datapath
// Delta, error-term and coordinate registers, plus the output register.
// ----------------------------------------------------------------------------
module blp_dp #(
	parameter int unsigned COORD_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  blp_pkg::blp_cmd_t     cmd,
	output blp_pkg::blp_status_t  status,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic [COORD_BITS-1:0] point_x,
	output logic [COORD_BITS-1:0] point_y,
	output logic                  last_point,
	output logic                  out_valid,
	input  logic                  out_ready
);

	// The error term stays within (-2M, 2M] for a major delta M below 2^COORD_BITS.
	localparam int unsigned ErrBits = COORD_BITS + 3;

	logic [COORD_BITS-1:0] cx_q, cy_q, adx_q, ady_q, rem_q;
	logic                  xneg_q, yneg_q, xmaj_q;
	logic [COORD_BITS:0]   major_two_q, minor_two_q;
	logic [ErrBits-1:0]    err_q;
	logic                  out_v_q;

	logic [COORD_BITS:0]   ddx, ddy;
	logic [COORD_BITS-1:0] adx_c, ady_c, major_c, minor_c;
	logic                  xmaj_c;
	logic [ErrBits-1:0]    err_init, err_next, err_sub;
	logic                  minor_step, maj_neg, step_x, step_y;
	logic [COORD_BITS-1:0] cx_next, cy_next;

	// Load: signed deltas and their magnitudes.
	always_comb begin
		ddx   = {1'b0, end_x} - {1'b0, start_x};
		ddy   = {1'b0, end_y} - {1'b0, start_y};
		adx_c = ddx[COORD_BITS] ? COORD_BITS'(~ddx + 1'b1) : ddx[COORD_BITS-1:0];
		ady_c = ddy[COORD_BITS] ? COORD_BITS'(~ddy + 1'b1) : ddy[COORD_BITS-1:0];
	end

	// Setup: x takes the major axis on a tie.
	always_comb begin
		xmaj_c   = adx_q >= ady_q;
		major_c  = xmaj_c ? adx_q : ady_q;
		minor_c  = xmaj_c ? ady_q : adx_q;
		err_init = ErrBits'({minor_c, 1'b0}) - ErrBits'(major_c);
	end

	// Step: the minor axis moves on a positive error, or on zero error when
	// the major direction is positive, which keeps lines symmetric.
	always_comb begin
		maj_neg    = xmaj_q ? xneg_q : yneg_q;
		minor_step = (!err_q[ErrBits-1] && (err_q != '0)) || ((err_q == '0) && !maj_neg);
		err_sub    = minor_step ? ErrBits'(major_two_q) : '0;
		err_next   = err_q + ErrBits'(minor_two_q) - err_sub;
		step_x     = xmaj_q || minor_step;
		step_y     = !xmaj_q || minor_step;
		cx_next    = cx_q;
		cy_next    = cy_q;
		if (step_x) begin
			cx_next = xneg_q ? cx_q - 1'b1 : cx_q + 1'b1;
		end
		if (step_y) begin
			cy_next = yneg_q ? cy_q - 1'b1 : cy_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q   <= start_x;
			cy_q   <= start_y;
			adx_q  <= adx_c;
			ady_q  <= ady_c;
			xneg_q <= ddx[COORD_BITS];
			yneg_q <= ddy[COORD_BITS];
		end
		if (cmd.setup) begin
			xmaj_q      <= xmaj_c;
			major_two_q <= {major_c, 1'b0};
			minor_two_q <= {minor_c, 1'b0};
			err_q       <= err_init;
			rem_q       <= major_c;
		end
		if (cmd.step) begin
			cx_q       <= cx_next;
			cy_q       <= cy_next;
			err_q      <= err_next;
			rem_q      <= rem_q - 1'b1;
			point_x    <= cx_next;
			point_y    <= cy_next;
			last_point <= status.last_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.step) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign out_valid        = out_v_q;
	assign status.len_zero  = (major_c == '0);
	assign status.last_step = (rem_q == COORD_BITS'(1));
	assign status.out_free  = !out_v_q || out_ready;

endmodule

[rtl/bresenham_line_points_top.sv]
// ----------------------------------------------------------------------------
// Bresenham line points: top level
// Turns a line given by its start and end points into a stream of points.
// ----------------------------------------------------------------------------
// Each beat on the line channel carries a start and an end point; the block
// answers with one beat per point of the Bresenham line, beginning at the point
// after the start and ending at the end point, whose beat has last_point set.
// A line whose start equals its end produces no beats at all. Lines are taken
// one at a time: the cycle that accepts a line also loads it, a setup state
// follows, then one point per cycle for as long as the point sink keeps
// ready high; the line channel is held off through setup and until the last
// point of the line has been stepped, and the point rate is set by the single
// error-term and coordinate update that runs once per point. The last point
// sits in the output register, so the next line can be accepted while it
// still waits to be taken.
// ----------------------------------------------------------------------------
module bresenham_line_points_top #(
	parameter int unsigned COORD_BITS = 6
) (
	input logic          clk,
	input logic          arst_n,
	blp_line_if.sink     lines,
	blp_point_if.source  points
);

	blp_pkg::blp_cmd_t    cmd;
	blp_pkg::blp_status_t status;

	// The controller alone decides when a line beat is accepted and when the
	// datapath advances; the datapath owns every coordinate register.
	blp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (lines.valid),
		.in_ready (lines.ready),
		.status   (status),
		.cmd      (cmd)
	);

	blp_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.start_x    (lines.start_x),
		.start_y    (lines.start_y),
		.end_x      (lines.end_x),
		.end_y      (lines.end_y),
		.point_x    (points.point_x),
		.point_y    (points.point_y),
		.last_point (points.last_point),
		.out_valid  (points.valid),
		.out_ready  (points.ready)
	);

endmodule

[rtl/blp_checker.sv]
// ----------------------------------------------------------------------------
// Bresenham line points: port checker
// Watches the top level's channels for properties of the point stream.
// ----------------------------------------------------------------------------
module blp_checker #(
	parameter int unsigned COORD_BITS = 6
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] point_x,
	input logic [COORD_BITS-1:0] point_y,
	input logic                  last_point
);

	// A stalled point beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
			&& $stable(last_point))
		else $error("point beat changed while stalled");

	// Lines are taken one at a time: ready drops for setup after each accepted line beat.
	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("line accepted during setup");

	// Back-to-back points of one line are neighbours on x.
	a_step_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_point ##1 out_valid && out_ready |->
			(point_x == $past(point_x)) || (point_x == $past(point_x) + 1'b1)
			|| (point_x == $past(point_x) - 1'b1))
		else $error("x jumped between points");

	// Back-to-back points of one line are neighbours on y and never repeat.
	a_step_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_point ##1 out_valid && out_ready |->
			((point_y == $past(point_y)) || (point_y == $past(point_y) + 1'b1)
			|| (point_y == $past(point_y) - 1'b1))
			&& !((point_x == $past(point_x)) && (point_y == $past(point_y))))
		else $error("y jumped or point repeated");

endmodule

bind bresenham_line_points_top blp_checker #(
	.COORD_BITS (COORD_BITS)
) u_blp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (lines.valid),
	.in_ready   (lines.ready),
	.out_valid  (points.valid),
	.out_ready  (points.ready),
	.point_x    (points.point_x),
	.point_y    (points.point_y),
	.last_point (points.last_point)
);
